FILE: rtl/selection_sort_defines.svh
// Assertion macros used by the selection sorter top level.
`ifndef SELECTION_SORT_DEFINES_SVH
`define SELECTION_SORT_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define SS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define SS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/ss_pkg.sv
// Shared widths, defaults and controller/datapath interface types for the selection sorter.
package ss_pkg;

   localparam int VALUE_W       = 32;
   localparam int MAX_ITEMS_DEF = 64;

   typedef struct packed {
      logic load;
      logic pass_rd;
      logic scan_rd;
      logic swap_lo;
      logic swap_hi;
      logic emit_rd;
      logic emit_next;
      logic run_done;
   } ss_cmd_type;

   typedef struct packed {
      logic pass_done;
      logic scan_last;
      logic emit_last;
   } ss_stat_type;

endpackage

FILE: rtl/selection_sort.sv
// Selection sorter top level: controller and datapath with interface checks.
// Loads a set of signed 32-bit values, one beat per cycle, until a beat with
// req_final_item; beats beyond MAX_ITEMS are dropped and flag rsp_overflow on
// every result of that set. The set is then sorted ascending in place, with a
// single-port scan of the element store: each pass does one compare per cycle
// plus setup, drain and a swap split into a low and a high write. Results then
// leave one beat at a time, each read from the store before it is offered, the
// last carrying rsp_end_of_run. No new set is taken until the last result beat
// of the current one is accepted. The store needs no clearing after reset.
`include "selection_sort_defines.svh"

module selection_sort #(
   parameter int MAX_ITEMS = ss_pkg::MAX_ITEMS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [ss_pkg::VALUE_W-1:0]  req_value,
   input  logic                               req_final_item,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [ss_pkg::VALUE_W-1:0]  rsp_sorted_value,
   output logic                               rsp_end_of_run,
   output logic                               rsp_overflow
);
   import ss_pkg::*;

   ss_cmd_type  cmd;
   ss_stat_type stat;

   ss_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_final_item (req_final_item),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .stat           (stat),
      .cmd            (cmd)
   );

   ss_dp #(
      .MAX_ITEMS (MAX_ITEMS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_value        (req_value),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_end_of_run   (rsp_end_of_run),
      .rsp_overflow     (rsp_overflow)
   );

   `SS_ASSERT_NOW(a_no_load_while_emit, rsp_valid, !req_ready, "input open during emit")
   `SS_ASSERT_NEXT(a_final_closes, req_valid && req_ready && req_final_item, !req_ready, "set not closed by final beat")
   `SS_ASSERT_NEXT(a_last_reopens, rsp_valid && rsp_ready && rsp_end_of_run, req_ready, "input not reopened after last beat")
   `SS_ASSERT_NEXT(a_swap_pairs, cmd.swap_lo, cmd.swap_hi, "swap half missing")

endmodule

FILE: rtl/ss_dp.sv
// Selection sorter datapath: element store, counters, running minimum and output fields.
module ss_dp #(
   parameter int MAX_ITEMS = ss_pkg::MAX_ITEMS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  ss_pkg::ss_cmd_type                 cmd,
   output ss_pkg::ss_stat_type                stat,
   input  logic signed [ss_pkg::VALUE_W-1:0]  req_value,
   output logic signed [ss_pkg::VALUE_W-1:0]  rsp_sorted_value,
   output logic                               rsp_end_of_run,
   output logic                               rsp_overflow
);
   import ss_pkg::*;

   localparam int IDX_W = $clog2(MAX_ITEMS);
   localparam int CNT_W = $clog2(MAX_ITEMS + 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(MAX_ITEMS);

   logic [VALUE_W-1:0] mem [MAX_ITEMS];

   logic [CNT_W-1:0]   count_ff, count_in;
   logic               ovf_ff, ovf_in;
   logic [IDX_W-1:0]   pos_ff, pos_in;
   logic [IDX_W-1:0]   scan_ff, scan_in;
   logic [IDX_W-1:0]   out_ff, out_in;
   logic               rd_live_ff, rd_live_in;
   logic               rd_first_ff, rd_first_in;
   logic [VALUE_W-1:0] rd_data_ff;
   logic [IDX_W-1:0]   rd_idx_ff;
   logic [VALUE_W-1:0] best_val_ff;
   logic [IDX_W-1:0]   best_idx_ff;
   logic [VALUE_W-1:0] held_ff;

   logic               full;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [VALUE_W-1:0] wr_data;
   logic               rd_en;
   logic [IDX_W-1:0]   rd_addr;
   logic               take;

   assign full = (count_ff >= FULL_COUNT);

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = count_ff[IDX_W-1:0];
      wr_data = req_value;
      if (cmd.load && !full) begin
         wr_en = 1'b1;
      end
      if (cmd.swap_lo) begin
         wr_en   = 1'b1;
         wr_addr = pos_ff;
         wr_data = best_val_ff;
      end
      if (cmd.swap_hi) begin
         wr_en   = 1'b1;
         wr_addr = best_idx_ff;
         wr_data = held_ff;
      end
   end

   assign rd_en   = cmd.pass_rd | cmd.scan_rd | cmd.emit_rd;
   assign rd_addr = cmd.pass_rd ? pos_ff : (cmd.scan_rd ? scan_ff : out_ff);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
         rd_idx_ff  <= rd_addr;
      end
   end

   // earliest minimum wins on ties: strict compare
   assign take = rd_live_ff &&
                 (rd_first_ff || ($signed(rd_data_ff) < $signed(best_val_ff)));

   always_ff @(posedge clock) begin
      if (take) begin
         best_val_ff <= rd_data_ff;
         best_idx_ff <= rd_idx_ff;
      end
      if (rd_live_ff && rd_first_ff) begin
         held_ff <= rd_data_ff;
      end
   end

   always_comb begin
      count_in    = count_ff;
      ovf_in      = ovf_ff;
      pos_in      = pos_ff;
      scan_in     = scan_ff;
      out_in      = out_ff;
      rd_live_in  = cmd.pass_rd | cmd.scan_rd;
      rd_first_in = cmd.pass_rd;
      if (cmd.load) begin
         if (full) begin
            ovf_in = 1'b1;
         end else begin
            count_in = count_ff + CNT_W'(1);
         end
      end
      if (cmd.pass_rd) begin
         scan_in = pos_ff + IDX_W'(1);
      end
      if (cmd.scan_rd) begin
         scan_in = scan_ff + IDX_W'(1);
      end
      if (cmd.swap_hi) begin
         pos_in = pos_ff + IDX_W'(1);
      end
      if (cmd.emit_next) begin
         out_in = out_ff + IDX_W'(1);
      end
      if (cmd.run_done) begin
         count_in = '0;
         ovf_in   = 1'b0;
         pos_in   = '0;
         out_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         ovf_ff      <= 1'b0;
         pos_ff      <= '0;
         scan_ff     <= '0;
         out_ff      <= '0;
         rd_live_ff  <= 1'b0;
         rd_first_ff <= 1'b0;
      end else begin
         count_ff    <= count_in;
         ovf_ff      <= ovf_in;
         pos_ff      <= pos_in;
         scan_ff     <= scan_in;
         out_ff      <= out_in;
         rd_live_ff  <= rd_live_in;
         rd_first_ff <= rd_first_in;
      end
   end

   assign stat.pass_done = (CNT_W'(pos_ff) + CNT_W'(1)) >= count_ff;
   assign stat.scan_last = (CNT_W'(scan_ff) + CNT_W'(1)) == count_ff;
   assign stat.emit_last = (CNT_W'(out_ff) + CNT_W'(1)) == count_ff;

   assign rsp_sorted_value = $signed(rd_data_ff);
   assign rsp_end_of_run   = stat.emit_last;
   assign rsp_overflow     = ovf_ff;

endmodule

FILE: rtl/ss_ctrl.sv
// Selection sorter controller: load, selection passes, swap and emit sequencing.
module ss_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_final_item,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  ss_pkg::ss_stat_type stat,
   output ss_pkg::ss_cmd_type  cmd
);
   import ss_pkg::*;

   typedef enum logic [7:0] {
      ST_LOAD    = 8'b0000_0001,
      ST_PASS    = 8'b0000_0010,
      ST_SCAN    = 8'b0000_0100,
      ST_DRAIN   = 8'b0000_1000,
      ST_SWAP_LO = 8'b0001_0000,
      ST_SWAP_HI = 8'b0010_0000,
      ST_EMIT_RD = 8'b0100_0000,
      ST_EMIT    = 8'b1000_0000
   } ss_state_type;

   ss_state_type state_ff, state_in;

   assign req_ready = (state_ff == ST_LOAD);
   assign rsp_valid = (state_ff == ST_EMIT);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_LOAD: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               if (req_final_item) begin
                  state_in = ST_PASS;
               end
            end
         end
         ST_PASS: begin
            if (stat.pass_done) begin
               state_in = ST_EMIT_RD;
            end else begin
               cmd.pass_rd = 1'b1;
               state_in    = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_rd = 1'b1;
            if (stat.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_SWAP_LO;
         end
         ST_SWAP_LO: begin
            cmd.swap_lo = 1'b1;
            state_in    = ST_SWAP_HI;
         end
         ST_SWAP_HI: begin
            cmd.swap_hi = 1'b1;
            state_in    = ST_PASS;
         end
         ST_EMIT_RD: begin
            cmd.emit_rd = 1'b1;
            state_in    = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_ready) begin
               if (stat.emit_last) begin
                  cmd.run_done = 1'b1;
                  state_in     = ST_LOAD;
               end else begin
                  cmd.emit_next = 1'b1;
                  state_in      = ST_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
